// ===== src/crc32e_pkg.sv =====
// Shared types, register map, reset values and bitwise CRC functions
// for the configurable CRC-32 engine. No dependencies.
package crc32e_pkg;

   localparam int unsigned ADDR_W      = 5;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [31:0] POLY_RESET  = 32'h04C1_1DB7;
   localparam logic [31:0] INIT_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] XOR_RESET   = 32'hFFFF_FFFF;
   localparam logic        LSB_RESET   = 1'b1;
   localparam logic        RIN_RESET   = 1'b0;
   localparam logic        ROUT_RESET  = 1'b0;

   typedef enum logic [2:0] {
      REG_POLYNOMIAL     = 3'd0,
      REG_INITIAL_VALUE  = 3'd1,
      REG_FINAL_XOR      = 3'd2,
      REG_LSB_FIRST_MODE = 3'd3,
      REG_REFLECT_INPUT  = 3'd4,
      REG_REFLECT_OUTPUT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0] polynomial;
      logic [31:0] initial_value;
      logic [31:0] final_xor;
      logic        lsb_first_mode;
      logic        reflect_input;
      logic        reflect_output;
   } cfg_type;

   typedef struct packed {
      logic [31:0] term;
      logic        last_byte;
   } work_type;

   typedef struct packed {
      logic push;
      logic full;
   } push_ctl_type;

   typedef struct packed {
      logic pop;
      logic avail;
   } pop_ctl_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
   endfunction

   function automatic logic [31:0] rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) r[i] = v[31-i];
      return r;
   endfunction

   function automatic logic [31:0] crc_byte_steps(input logic [31:0] crc_in,
                                                  input logic        lsb_first,
                                                  input logic [31:0] poly);
      logic [31:0] crc;
      logic [31:0] rpoly;
      crc   = crc_in;
      rpoly = rev32(poly);
      for (int j = 0; j < 8; j++) begin
         if (lsb_first) begin
            crc = crc[0] ? ((crc >> 1) ^ rpoly) : (crc >> 1);
         end else begin
            crc = crc[31] ? ((crc << 1) ^ poly) : (crc << 1);
         end
      end
      return crc;
   endfunction

endpackage

// ===== src/crc32e_if.sv =====
// Valid/ready channel interfaces for request and response items.
// No dependencies.
interface crc32e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface crc32e_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;
   logic        message_done;
   modport source (output valid, crc_value, message_done, input ready);
   modport sink   (input valid, crc_value, message_done, output ready);
endinterface

// ===== src/configurable_crc32_engine_top.sv =====
// Configurable CRC-32 engine: one message byte per request item, one
// running CRC per response item.
//
// req_ch carries data_byte and last_byte; rsp_ch returns crc_value, the
// finished CRC over the message so far, and message_done, the echo of
// last_byte. The first byte after reset or after a last byte seeds the
// CRC fold with initial_value. Registers sit on an APB-style port at
// byte addresses 4*i: polynomial, initial_value, final_xor,
// lsb_first_mode, reflect_input, reflect_output. Write them only while
// the engine holds no item.
//
// Requests pass through the queue, then the response register. Throughput
// is one item per cycle unless rsp_ch stalls: the eight-step fold in the
// back end closes on the CRC register each cycle. A queue of QueueDepth
// items and the response register let requests continue while rsp_ch
// stalls; req_ch drops ready only when the queue is full. Reset clears the
// queue, the response valid bit, the CRC register and the open-message
// flag, and loads the register defaults. Depends on crc32e_pkg, crc32e_if.
module configurable_crc32_engine_top
   import crc32e_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   crc32e_req_if.sink        req_ch,
   crc32e_rsp_if.source      rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type      cfg;
   push_ctl_type push_ctl;
   pop_ctl_type  pop_ctl;
   work_type     wr_item;
   work_type     rd_item;
   logic         q_full;
   logic         q_avail;
   logic         q_pop;

   assign pop_ctl.pop   = q_pop;
   assign pop_ctl.avail = q_avail;

   crc32e_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crc32e_front u_front (
      .req_ch   (req_ch),
      .cfg      (cfg),
      .q_full   (q_full),
      .push_ctl (push_ctl),
      .work     (wr_item)
   );

   crc32e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_ctl (push_ctl),
      .wr_item  (wr_item),
      .full     (q_full),
      .pop      (pop_ctl.pop),
      .avail    (q_avail),
      .rd_item  (rd_item)
   );

   crc32e_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .pop_ctl (pop_ctl),
      .rd_item (rd_item),
      .pop     (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== src/crc32e_csr.sv =====
// APB-style configuration register bank for the CRC-32 engine.
// Depends on crc32e_pkg.
module crc32e_csr
   import crc32e_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_POLYNOMIAL:     cfg_in.polynomial     = pwdata;
            REG_INITIAL_VALUE:  cfg_in.initial_value  = pwdata;
            REG_FINAL_XOR:      cfg_in.final_xor      = pwdata;
            REG_LSB_FIRST_MODE: cfg_in.lsb_first_mode = pwdata[0];
            REG_REFLECT_INPUT:  cfg_in.reflect_input  = pwdata[0];
            REG_REFLECT_OUTPUT: cfg_in.reflect_output = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_POLYNOMIAL:     prdata = cfg_ff.polynomial;
         REG_INITIAL_VALUE:  prdata = cfg_ff.initial_value;
         REG_FINAL_XOR:      prdata = cfg_ff.final_xor;
         REG_LSB_FIRST_MODE: prdata = {31'd0, cfg_ff.lsb_first_mode};
         REG_REFLECT_INPUT:  prdata = {31'd0, cfg_ff.reflect_input};
         REG_REFLECT_OUTPUT: prdata = {31'd0, cfg_ff.reflect_output};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial     <= POLY_RESET;
         cfg_ff.initial_value  <= INIT_RESET;
         cfg_ff.final_xor      <= XOR_RESET;
         cfg_ff.lsb_first_mode <= LSB_RESET;
         cfg_ff.reflect_input  <= RIN_RESET;
         cfg_ff.reflect_output <= ROUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/crc32e_front.sv =====
// Front end: accepts request items and aligns each byte into a 32-bit
// fold term for the selected bit order. Depends on crc32e_pkg, crc32e_if.
module crc32e_front
   import crc32e_pkg::*;
(
   crc32e_req_if.sink req_ch,
   input  cfg_type      cfg,
   input  logic         q_full,
   output push_ctl_type push_ctl,
   output work_type     work
);

   logic [7:0] byte_sel;

   assign req_ch.ready  = ~q_full;
   assign push_ctl.push = req_ch.valid & ~q_full;
   assign push_ctl.full = q_full;

   always_comb begin
      byte_sel = (cfg.reflect_input & ~cfg.lsb_first_mode) ? rev8(req_ch.data_byte)
                                                           : req_ch.data_byte;
      if (cfg.lsb_first_mode) begin
         work.term = {24'd0, byte_sel};
      end else begin
         work.term = {byte_sel, 24'd0};
      end
      work.last_byte = req_ch.last_byte;
   end

endmodule

// ===== src/crc32e_queue.sv =====
// Small FIFO of work items between front and back ends.
// Depends on crc32e_pkg.
module crc32e_queue
   import crc32e_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  push_ctl_type push_ctl,
   input  work_type     wr_item,
   output logic         full,
   input  logic         pop,
   output logic         avail,
   output work_type     rd_item
);

   localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CW = $clog2(Depth + 1);

   work_type        mem [Depth];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(Depth));
   assign avail   = (count_ff != '0);
   assign do_push = push_ctl.push & ~full;
   assign do_pop  = pop & avail;
   assign rd_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/crc32e_back.sv =====
// Back end: folds each queued byte into the running CRC register and
// holds the finished result in the output register. Depends on crc32e_pkg, crc32e_if.
module crc32e_back
   import crc32e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  pop_ctl_type pop_ctl,
   input  work_type    rd_item,
   output logic        pop,
   crc32e_rsp_if.source rsp_ch
);

   logic [31:0] crc_ff, crc_in;
   logic        in_msg_ff, in_msg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [31:0] seed;
   logic [31:0] folded;
   logic        take;

   assign take   = pop_ctl.avail & (~rsp_valid_ff | rsp_ch.ready);
   assign pop    = take;
   assign seed   = in_msg_ff ? crc_ff : cfg.initial_value;
   assign folded = crc_byte_steps(seed ^ rd_item.term, cfg.lsb_first_mode, cfg.polynomial);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.crc_value    = rsp_crc_ff;
   assign rsp_ch.message_done = rsp_done_ff;

   always_comb begin
      crc_in       = crc_ff;
      in_msg_in    = in_msg_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      if (take) begin
         crc_in       = folded;
         in_msg_in    = ~rd_item.last_byte;
         rsp_crc_in   = (cfg.reflect_output ? rev32(folded) : folded) ^ cfg.final_xor;
         rsp_done_in  = rd_item.last_byte;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff  <= rsp_crc_in;
      rsp_done_ff <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
